// File: design/dde_pkg.sv
`default_nettype none

package dde_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam logic [15:0] COUNT_MIDPOINT = 16'd32767;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd2;
  localparam logic [15:0] TPS_RESET = 16'd1000;

  localparam int unsigned MUL_A_W = 48;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned CORD_W = 34;
  localparam logic signed [CORD_W-1:0] CORD_GAIN_INV = 34'sh026DD3B6A;

  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/dde_in_if.sv
`default_nettype none

interface dde_in_if;
  logic valid;
  logic ready;
  logic [15:0] left_count;
  logic [15:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink (input valid, input left_count, input right_count, output ready);
endinterface

`default_nettype wire

// File: design/dde_out_if.sv
`default_nettype none

interface dde_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] speed_left;
  logic signed [31:0] speed_right;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0] heading;

  modport source (output valid, output speed_left, output speed_right, output pos_x,
                  output pos_y, output heading, input ready);
  modport sink (input valid, input speed_left, input speed_right, input pos_x,
                input pos_y, input heading, output ready);
endinterface

`default_nettype wire

// File: design/dde_mul.sv
`default_nettype none

// Unsigned shift-add multiplier that retires one multiplier bit per cycle.
module dde_mul import dde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] prod_o,
  output logic               busy_o,
  output logic               done_o
);

  localparam int unsigned CW = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_P_W-1:0] p_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;
  logic [MUL_A_W:0]   part_sum;

  assign part_sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {part_sum, p_q[MUL_B_W-1:1]};
    end
  end

  assign prod_o = p_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/dde_cordic.sv
`default_nettype none

// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module dde_cordic import dde_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              angle_i,
  output logic signed [CORD_W-1:0] cos_o,
  output logic signed [CORD_W-1:0] sin_o,
  output logic                     done_o
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS);

  logic signed [CORD_W-1:0] x_q, y_q, z_q;
  logic signed [CORD_W-1:0] z0, dx, dy, at;
  logic                     flip_q, run_q, done_q;
  logic [IW-1:0]            i_q;

  assign z0 = CORD_W'($signed(angle_i));
  assign dx = x_q >>> i_q;
  assign dy = y_q >>> i_q;
  assign at = $signed({2'b00, atan_lookup(5'(i_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (run_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == IW'(CORDIC_STEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORD_GAIN_INV;
      y_q <= '0;
      if (z0 > 34'sh040000000) begin
        z_q    <= z0 - 34'sh080000000;
        flip_q <= 1'b1;
      end else if (z0 < -34'sh040000000) begin
        z_q    <= z0 + 34'sh080000000;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z0;
        flip_q <= 1'b0;
      end
    end else if (run_q) begin
      if (!z_q[CORD_W-1]) begin
        x_q <= x_q - dy;
        y_q <= y_q + dx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dy;
        y_q <= y_q - dx;
        z_q <= z_q + at;
      end
    end
  end

  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/differential_drive_odometry.sv
// Each accepted item runs seven products in turn through the shared
// one-bit-per-cycle multiplier, and the results then load the output
// register. No new item is taken until the output register is loaded;
// the sine and cosine of the heading are computed in parallel with the
// first products.
// Reset clears position and heading to zero and the registers to distance 0,
// heading gain 0 and 1000 ticks per second.
`default_nettype none

module differential_drive_odometry import dde_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dde_in_if.sink                in_i,
  dde_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    MOP_DL, MOP_DR, MOP_SL, MOP_SR, MOP_X, MOP_Y, MOP_H
  } mop_e;

  localparam logic [46:0] ACC_MAX = {47{1'b1}};
  localparam logic signed [49:0] ACC_HI = $signed({3'b000, ACC_MAX});
  localparam logic signed [49:0] ACC_LO = -ACC_HI;

  state_e state_q;
  mop_e   op_q, op_next;
  logic   go_q;

  logic [23:0] dpc_q;
  logic [31:0] hpc_q;
  logic [15:0] tps_q;

  logic signed [16:0] dlc_q, drc_q;
  logic signed [41:0] dl_q, dr_q;
  logic signed [47:0] xacc_q, yacc_q;
  logic [31:0]        heading_q;
  logic signed [31:0] spl_q, spr_q;

  logic               out_vld_q;
  logic signed [31:0] o_spl_q, o_spr_q, o_x_q, o_y_q;
  logic [31:0]        o_head_q;

  logic signed [CORD_W-1:0] cos_w, sin_w;
  logic                     cord_done;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               mul_start, mul_busy, mul_done;

  logic               in_acc;
  logic signed [41:0] sum_w;
  logic signed [17:0] diff_w;
  logic [16:0]        abs_dlc, abs_drc, abs_diff;
  logic [41:0]        abs_sum, abs_dl, abs_dr;
  logic [CORD_W-1:0]  abs_c, abs_s;
  logic               neg;
  logic [MUL_P_W:0]   prod_s;
  logic signed [49:0] sp_w;
  logic signed [31:0] sp_sat;
  logic [50:0]        r_w;
  logic [46:0]        r_cl;
  logic signed [49:0] inc_w, acc_old, acc_sum;
  logic signed [47:0] acc_sat;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q <= '0;
      hpc_q <= '0;
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIST_PER_COUNT: dpc_q <= cfg_data_i[23:0];
        CFG_HEAD_PER_COUNT: hpc_q <= cfg_data_i;
        CFG_TICKS_PER_SEC:  tps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  dde_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .angle_i (heading_q),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .done_o  (cord_done)
  );

  dde_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .busy_o  (mul_busy),
    .done_o  (mul_done)
  );

  assign sum_w    = dl_q + dr_q;
  assign diff_w   = {drc_q[16], drc_q} - {dlc_q[16], dlc_q};
  assign abs_dlc  = dlc_q[16] ? 17'(-dlc_q) : dlc_q;
  assign abs_drc  = drc_q[16] ? 17'(-drc_q) : drc_q;
  assign abs_diff = diff_w[17] ? 17'(-diff_w) : diff_w[16:0];
  assign abs_sum  = sum_w[41] ? -sum_w : sum_w;
  assign abs_dl   = dl_q[41] ? -dl_q : dl_q;
  assign abs_dr   = dr_q[41] ? -dr_q : dr_q;
  assign abs_c    = cos_w[CORD_W-1] ? -cos_w : cos_w;
  assign abs_s    = sin_w[CORD_W-1] ? -sin_w : sin_w;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg   = 1'b0;
    case (op_q)
      MOP_DL: begin
        mul_a = MUL_A_W'(dpc_q);
        mul_b = MUL_B_W'(abs_dlc);
        neg   = dlc_q[16];
      end
      MOP_DR: begin
        mul_a = MUL_A_W'(dpc_q);
        mul_b = MUL_B_W'(abs_drc);
        neg   = drc_q[16];
      end
      MOP_SL: begin
        mul_a = MUL_A_W'(abs_dl);
        mul_b = MUL_B_W'(tps_q);
        neg   = dl_q[41];
      end
      MOP_SR: begin
        mul_a = MUL_A_W'(abs_dr);
        mul_b = MUL_B_W'(tps_q);
        neg   = dr_q[41];
      end
      MOP_X: begin
        mul_a = MUL_A_W'(abs_sum);
        mul_b = abs_c[MUL_B_W-1:0];
        neg   = sum_w[41] ^ cos_w[CORD_W-1];
      end
      MOP_Y: begin
        mul_a = MUL_A_W'(abs_sum);
        mul_b = abs_s[MUL_B_W-1:0];
        neg   = sum_w[41] ^ sin_w[CORD_W-1];
      end
      MOP_H: begin
        mul_a = MUL_A_W'(hpc_q);
        mul_b = MUL_B_W'(abs_diff);
        neg   = diff_w[17];
      end
      default: ;
    endcase
  end

  always_comb begin
    case (op_q)
      MOP_DL:  op_next = MOP_DR;
      MOP_DR:  op_next = MOP_SL;
      MOP_SL:  op_next = MOP_SR;
      MOP_SR:  op_next = MOP_X;
      MOP_X:   op_next = MOP_Y;
      MOP_Y:   op_next = MOP_H;
      default: op_next = MOP_DL;
    endcase
  end

  assign mul_start = (state_q == ST_MUL) && go_q && (op_q != MOP_X || cord_done);

  // Signed product; speeds and heading take floor shifts straight from it.
  assign prod_s = neg ? -{1'b0, prod} : {1'b0, prod};
  assign sp_w   = $signed(prod_s[57:8]);
  always_comb begin
    if (sp_w > 50'sh0_0000_7FFF_FFFF) begin
      sp_sat = 32'sh7FFF_FFFF;
    end else if (sp_w < -50'sh0_0000_8000_0000) begin
      sp_sat = -32'sh8000_0000;
    end else begin
      sp_sat = sp_w[31:0];
    end
  end

  // Position increment truncates toward zero, so it works on the magnitude.
  assign r_w     = prod[73:23];
  assign r_cl    = (r_w[50:47] != 4'd0) ? ACC_MAX : r_w[46:0];
  assign inc_w   = neg ? -$signed({3'b000, r_cl}) : $signed({3'b000, r_cl});
  assign acc_old = (op_q == MOP_Y) ? 50'(yacc_q) : 50'(xacc_q);
  assign acc_sum = acc_old + inc_w;
  always_comb begin
    if (acc_sum > ACC_HI) begin
      acc_sat = ACC_HI[47:0];
    end else if (acc_sum < ACC_LO) begin
      acc_sat = ACC_LO[47:0];
    end else begin
      acc_sat = acc_sum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= MOP_DL;
      go_q      <= 1'b0;
      xacc_q    <= '0;
      yacc_q    <= '0;
      heading_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (mul_start) begin
        go_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_MUL;
            op_q    <= MOP_DL;
            go_q    <= 1'b1;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (op_q)
              MOP_X: xacc_q <= acc_sat;
              MOP_Y: yacc_q <= acc_sat;
              MOP_H: heading_q <= heading_q + prod_s[39:8];
              default: ;
            endcase
            op_q <= op_next;
            if (op_q == MOP_H) begin
              state_q <= ST_DONE;
            end else begin
              go_q <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dlc_q <= $signed({1'b0, COUNT_MIDPOINT}) - $signed({1'b0, in_i.left_count});
      drc_q <= $signed({1'b0, COUNT_MIDPOINT}) - $signed({1'b0, in_i.right_count});
    end
    if (state_q == ST_MUL && mul_done) begin
      case (op_q)
        MOP_DL: dl_q <= prod_s[41:0];
        MOP_DR: dr_q <= prod_s[41:0];
        MOP_SL: spl_q <= sp_sat;
        MOP_SR: spr_q <= sp_sat;
        default: ;
      endcase
    end
    if (state_q == ST_DONE && (!out_vld_q || out_o.ready)) begin
      o_spl_q  <= spl_q;
      o_spr_q  <= spr_q;
      o_x_q    <= xacc_q[47:16];
      o_y_q    <= yacc_q[47:16];
      o_head_q <= heading_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.speed_left  = o_spl_q;
  assign out_o.speed_right = o_spr_q;
  assign out_o.pos_x       = o_x_q;
  assign out_o.pos_y       = o_y_q;
  assign out_o.heading     = o_head_q;

`ifndef NO_ASSERTIONS
  a_cordic_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done && (op_q == MOP_X || op_q == MOP_Y)) |-> cord_done)
    else $error("position product finished before the sine and cosine");

  a_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mul_busy)
    else $error("multiplier busy while the block takes a new item");

  a_heading_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && op_q == MOP_H && state_q == ST_MUL) |=> $stable(heading_q))
    else $error("heading changed outside its update");
`endif

endmodule

`default_nettype wire
